// ===== src/sus_pkg.sv =====
package sus_pkg;

   localparam int KEY_W = 16;

   // request operation codes
   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // response status codes
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_DUPLICATE = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]       func;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       is_member;
   } rsp_type;

   // write enables of the node pool
   typedef struct packed {
      logic key;
      logic link;
   } pool_wen_type;

endpackage

// ===== src/sus_pool.sv =====
module sus_pool #(
   parameter int POOL_SIZE = 32
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [$clog2(POOL_SIZE)-1:0]         rd_addr,
   input  sus_pkg::pool_wen_type                wr_en,
   input  logic [$clog2(POOL_SIZE)-1:0]         wr_addr,
   input  logic [sus_pkg::KEY_W-1:0]            wr_key,
   input  logic [$clog2(POOL_SIZE+1)-1:0]       wr_link,
   output logic [sus_pkg::KEY_W-1:0]            rd_key,
   output logic [$clog2(POOL_SIZE+1)-1:0]       rd_link
);

   localparam int LW = $clog2(POOL_SIZE + 1);

   logic [sus_pkg::KEY_W-1:0] key_mem [POOL_SIZE];
   logic [LW-1:0]             link_mem [POOL_SIZE];
   logic [sus_pkg::KEY_W-1:0] rd_key_ff;
   logic [LW-1:0]             rd_link_ff;

   always_ff @(posedge clock) begin
      if (wr_en.key) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (wr_en.link) begin
         link_mem[wr_addr] <= wr_link;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_link_ff <= link_mem[rd_addr];
      end
   end

   assign rd_key  = rd_key_ff;
   assign rd_link = rd_link_ff;

endmodule

// ===== src/sorted_unique_set_store.sv =====
// sorted set of unique 16-bit keys, kept as an ascending linked list in a node pool
//
// req channel: one beat carries func (insert, delete, query) and key; accepted
//   when req_valid is high and req_stall is low
// rsp channel: one beat per request with status and is_member, held in an
//   output register until the receiver drops rsp_stall
// walk: a request walks the list one node per cycle through the pool's
//   read port; a query then passes S_DEC and S_DONE, a found delete adds
//   S_LNK, and an insert with a free node adds S_INS and S_LNK
// insert pops the free list then patches the predecessor link or list head;
//   delete pushes the node onto the free list then patches the link
// requests run one at a time: req_stall stays high from acceptance until the
//   response is loaded, and the next is taken once the state is back in S_IDLE
// reset: list empty, free list starts at node 0; a pass in S_INIT over all
//   POOL_SIZE nodes then chains the free list (node i links to i + 1) and
//   req_stall stays high until it ends
// a stalled response beat stays in the output register; the next request is
//   still taken and walked, and waits only at its final step for the register
module sorted_unique_set_store #(
   parameter int POOL_SIZE = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sus_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sus_pkg::rsp_type  rsp_data
);

   localparam int IW = $clog2(POOL_SIZE);
   localparam int LW = $clog2(POOL_SIZE + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SIZE);
   localparam logic [IW-1:0] LAST_NODE = IW'(POOL_SIZE - 1);

   typedef enum logic [6:0] {
      S_INIT = 7'b0000001,   // chaining the free list after reset
      S_IDLE = 7'b0000010,
      S_WALK = 7'b0000100,   // node data back from the pool, compare
      S_DEC  = 7'b0001000,   // position known, decide the update
      S_INS  = 7'b0010000,   // pop free node, write new node
      S_LNK  = 7'b0100000,   // patch predecessor link or list head
      S_DONE = 7'b1000000    // hand result to the output register
   } state_type;

   state_type                 state_ff, state_in;
   logic [IW-1:0]             init_cnt_ff, init_cnt_in;
   logic [LW-1:0]             list_head_ff, list_head_in;
   logic [LW-1:0]             free_head_ff, free_head_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sus_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   // per-request working registers
   logic [1:0]                func_ff, func_in;
   logic [sus_pkg::KEY_W-1:0] key_ff, key_in;
   logic [LW-1:0]             prev_ff, prev_in;
   logic [LW-1:0]             cur_ff, cur_in;
   logic [LW-1:0]             cur_link_ff, cur_link_in;
   logic [LW-1:0]             tgt_ff, tgt_in;
   logic [LW-1:0]             steps_ff, steps_in;
   logic                      found_ff, found_in;
   logic [1:0]                status_ff, status_in;
   logic                      member_ff, member_in;

   // pool access
   logic                      rd_en;
   logic [IW-1:0]             rd_addr;
   sus_pkg::pool_wen_type     wr_en;
   logic [IW-1:0]             wr_addr;
   logic [sus_pkg::KEY_W-1:0] wr_key;
   logic [LW-1:0]             wr_link;
   logic [sus_pkg::KEY_W-1:0] rd_key;
   logic [LW-1:0]             rd_link;

   logic                      req_fire;
   logic [LW-1:0]             steps_nxt;

   sus_pool #(
      .POOL_SIZE (POOL_SIZE)
   ) u_pool (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .wr_link (wr_link),
      .rd_key  (rd_key),
      .rd_link (rd_link)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign steps_nxt = steps_ff + LW'(1);

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      // output beat leaves when the receiver takes it
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      cur_link_in  = cur_link_ff;
      tgt_in       = tgt_ff;
      steps_in     = steps_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      member_in    = member_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = '0;
      wr_addr      = '0;
      wr_key       = key_ff;
      wr_link      = '0;

      case (state_ff)
         S_INIT: begin
            wr_en.link  = 1'b1;
            wr_addr     = init_cnt_ff;
            wr_link     = LW'(init_cnt_ff) + LW'(1);
            init_cnt_in = init_cnt_ff + IW'(1);
            if (init_cnt_ff == LAST_NODE) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               func_in  = req_data.func;
               key_in   = req_data.key;
               prev_in  = NULL_LINK;
               steps_in = '0;
               cur_in   = list_head_ff;
               found_in = 1'b0;
               if (req_data.func == sus_pkg::FUNC_NONE) begin
                  // unused code: no change, plain result
                  status_in = sus_pkg::STAT_OK;
                  member_in = 1'b0;
                  state_in  = S_DONE;
               end else if (list_head_ff < NULL_LINK) begin
                  rd_en    = 1'b1;
                  rd_addr  = list_head_ff[IW-1:0];
                  state_in = S_WALK;
               end else begin
                  cur_in   = NULL_LINK;
                  state_in = S_DEC;
               end
            end
         end

         S_WALK: begin
            if (rd_key >= key_ff) begin
               // first node not below the key
               found_in    = (rd_key == key_ff);
               cur_link_in = rd_link;
               state_in    = S_DEC;
            end else begin
               prev_in  = cur_ff;
               cur_in   = rd_link;
               steps_in = steps_nxt;
               if ((rd_link < NULL_LINK) && (steps_nxt < NULL_LINK)) begin
                  rd_en   = 1'b1;
                  rd_addr = rd_link[IW-1:0];
               end else begin
                  // end of list or walk bound reached
                  cur_in   = NULL_LINK;
                  found_in = 1'b0;
                  state_in = S_DEC;
               end
            end
         end

         S_DEC: begin
            state_in = S_DONE;
            case (func_ff)
               sus_pkg::FUNC_INSERT: begin
                  if (found_ff) begin
                     status_in = sus_pkg::STAT_DUPLICATE;
                     member_in = 1'b1;
                  end else if (!(free_head_ff < NULL_LINK)) begin
                     status_in = sus_pkg::STAT_FULL;
                     member_in = 1'b0;
                  end else begin
                     // fetch the free node's link to pop it
                     rd_en    = 1'b1;
                     rd_addr  = free_head_ff[IW-1:0];
                     state_in = S_INS;
                  end
               end
               sus_pkg::FUNC_DELETE: begin
                  member_in = 1'b0;
                  if (found_ff) begin
                     // push the node onto the free list
                     wr_en.link   = 1'b1;
                     wr_addr      = cur_ff[IW-1:0];
                     wr_link      = free_head_ff;
                     free_head_in = cur_ff;
                     tgt_in       = cur_link_ff;
                     status_in    = sus_pkg::STAT_OK;
                     state_in     = S_LNK;
                  end else begin
                     status_in = sus_pkg::STAT_NOT_FOUND;
                  end
               end
               sus_pkg::FUNC_QUERY: begin
                  status_in = found_ff ? sus_pkg::STAT_OK : sus_pkg::STAT_NOT_FOUND;
                  member_in = found_ff;
               end
               default: begin
                  status_in = sus_pkg::STAT_OK;
                  member_in = 1'b0;
               end
            endcase
         end

         S_INS: begin
            free_head_in = rd_link;
            wr_en.key    = 1'b1;
            wr_en.link   = 1'b1;
            wr_addr      = free_head_ff[IW-1:0];
            wr_key       = key_ff;
            wr_link      = cur_ff;
            tgt_in       = free_head_ff;
            status_in    = sus_pkg::STAT_OK;
            member_in    = 1'b1;
            state_in     = S_LNK;
         end

         S_LNK: begin
            if (prev_ff < NULL_LINK) begin
               wr_en.link = 1'b1;
               wr_addr    = prev_ff[IW-1:0];
               wr_link    = tgt_ff;
            end else begin
               list_head_in = tgt_ff;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = status_ff;
               rsp_data_in.is_member = member_ff;
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         list_head_ff <= NULL_LINK;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      func_ff     <= func_in;
      key_ff      <= key_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      cur_link_ff <= cur_link_in;
      tgt_ff      <= tgt_in;
      steps_ff    <= steps_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      member_ff   <= member_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
